FILE: design/swd_pkg.sv
package swd_pkg;

    // fixed field widths
    localparam int CFG_IDX_BITS   = 2;
    localparam int CFG_DATA_BITS  = 16;
    localparam int MIN_BITS       = 12;
    localparam int SETTLE_BITS    = 12;
    localparam int SETTLE_SQ_BITS = 2 * SETTLE_BITS;
    localparam int RATIO_BITS     = 16;
    localparam int DIR_BITS       = 3;
    localparam int OUT_TDATA_BITS = 8;

    // register indexes
    localparam logic [CFG_IDX_BITS-1:0] CFG_MIN_DISTANCE    = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_SETTLE_DISTANCE = 2'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_AXIS_RATIO      = 2'd2;

    // register reset values
    localparam logic [MIN_BITS-1:0]       MIN_DISTANCE_RST = 12'd24;
    localparam logic [SETTLE_SQ_BITS-1:0] SETTLE_SQ_RST    = 24'd9;  // 3 squared
    localparam logic [RATIO_BITS-1:0]     AXIS_RATIO_RST   = 16'd256;

    // op codes
    localparam logic OP_SAMPLE  = 1'b0;
    localparam logic OP_RELEASE = 1'b1;

    // direction codes
    localparam logic [DIR_BITS-1:0] DIR_NONE  = 3'd0;
    localparam logic [DIR_BITS-1:0] DIR_UP    = 3'd1;
    localparam logic [DIR_BITS-1:0] DIR_DOWN  = 3'd2;
    localparam logic [DIR_BITS-1:0] DIR_LEFT  = 3'd3;
    localparam logic [DIR_BITS-1:0] DIR_RIGHT = 3'd4;

    // shape of the peak displacement, tracker to classifier
    typedef struct packed {
        logic horiz;     // |dx| > |dy|
        logic negative;  // major-axis displacement is negative
    } swd_flags_t;

endpackage

FILE: design/swd_tracker.sv
module swd_tracker #(
    parameter int COORD_BITS = 12
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                step,
    input  logic                                op,
    input  logic [COORD_BITS-1:0]               pos_x,
    input  logic [COORD_BITS-1:0]               pos_y,
    input  logic [swd_pkg::SETTLE_SQ_BITS-1:0]  settle_sq,
    output logic                                tracking,
    output logic [COORD_BITS-1:0]               far_major,
    output logic [COORD_BITS-1:0]               far_minor,
    output swd_pkg::swd_flags_t                 far_flags
);
    import swd_pkg::*;

    localparam int C  = COORD_BITS;
    localparam int SQ = 2 * C;
    localparam int DW = SQ + 1;
    localparam int CW = (DW > SETTLE_SQ_BITS) ? DW : SETTLE_SQ_BITS;

    logic          tracking_reg;
    logic [C-1:0]  origin_x_reg, origin_y_reg;
    logic [C-1:0]  settled_x_reg, settled_y_reg;
    logic [DW-1:0] s_dist_reg, f_dist_reg;
    logic [C-1:0]  s_major_reg, s_minor_reg, f_major_reg, f_minor_reg;
    swd_flags_t    s_flags_reg, f_flags_reg;

    logic [C-1:0]  ps_ax, ps_ay, po_ax, po_ay;
    logic          po_xneg, po_yneg;
    logic [SQ-1:0] sq_ps_x, sq_ps_y, sq_po_x, sq_po_y;
    logic [DW-1:0] d_ps, d_po;
    logic          move;
    logic [C-1:0]  po_major, po_minor;
    swd_flags_t    po_flags;
    logic [DW-1:0] ns_dist;
    logic [C-1:0]  ns_major, ns_minor;
    swd_flags_t    ns_flags;
    logic          grow;

    // displacements of the sample from the settled point and from the origin
    always_comb
    begin
        ps_ax   = (pos_x >= settled_x_reg) ? pos_x - settled_x_reg : settled_x_reg - pos_x;
        ps_ay   = (pos_y >= settled_y_reg) ? pos_y - settled_y_reg : settled_y_reg - pos_y;
        po_xneg = pos_x < origin_x_reg;
        po_yneg = pos_y < origin_y_reg;
        po_ax   = po_xneg ? origin_x_reg - pos_x : pos_x - origin_x_reg;
        po_ay   = po_yneg ? origin_y_reg - pos_y : pos_y - origin_y_reg;
    end

    assign sq_ps_x = SQ'(ps_ax) * SQ'(ps_ax);
    assign sq_ps_y = SQ'(ps_ay) * SQ'(ps_ay);
    assign sq_po_x = SQ'(po_ax) * SQ'(po_ax);
    assign sq_po_y = SQ'(po_ay) * SQ'(po_ay);
    assign d_ps    = DW'(sq_ps_x) + DW'(sq_ps_y);
    assign d_po    = DW'(sq_po_x) + DW'(sq_po_y);

    assign move = CW'(d_ps) >= CW'(settle_sq);

    always_comb
    begin
        po_flags.horiz    = po_ax > po_ay;
        po_flags.negative = po_flags.horiz ? po_xneg : po_yneg;
        po_major          = po_flags.horiz ? po_ax : po_ay;
        po_minor          = po_flags.horiz ? po_ay : po_ax;
    end

    // settled point after this sample, then peak follows it if at least as far
    always_comb
    begin
        ns_dist  = move ? d_po     : s_dist_reg;
        ns_major = move ? po_major : s_major_reg;
        ns_minor = move ? po_minor : s_minor_reg;
        ns_flags = move ? po_flags : s_flags_reg;
        grow     = ns_dist >= f_dist_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tracking_reg <= 1'b0;
        end
        else if (step)
        begin
            tracking_reg <= (op == OP_SAMPLE);
        end
    end

    always_ff @(posedge clk)
    begin
        if (step && op == OP_SAMPLE)
        begin
            if (!tracking_reg)
            begin
                origin_x_reg  <= pos_x;
                origin_y_reg  <= pos_y;
                settled_x_reg <= pos_x;
                settled_y_reg <= pos_y;
                s_dist_reg    <= '0;
                s_major_reg   <= '0;
                s_minor_reg   <= '0;
                s_flags_reg   <= '0;
                f_dist_reg    <= '0;
                f_major_reg   <= '0;
                f_minor_reg   <= '0;
                f_flags_reg   <= '0;
            end
            else
            begin
                if (move)
                begin
                    settled_x_reg <= pos_x;
                    settled_y_reg <= pos_y;
                end
                s_dist_reg  <= ns_dist;
                s_major_reg <= ns_major;
                s_minor_reg <= ns_minor;
                s_flags_reg <= ns_flags;
                if (grow)
                begin
                    f_dist_reg  <= ns_dist;
                    f_major_reg <= ns_major;
                    f_minor_reg <= ns_minor;
                    f_flags_reg <= ns_flags;
                end
            end
        end
    end

    assign tracking  = tracking_reg;
    assign far_major = f_major_reg;
    assign far_minor = f_minor_reg;
    assign far_flags = f_flags_reg;

endmodule

FILE: design/swd_classify.sv
module swd_classify #(
    parameter int COORD_BITS = 12
) (
    input  logic                            tracking,
    input  logic [COORD_BITS-1:0]           far_major,
    input  logic [COORD_BITS-1:0]           far_minor,
    input  swd_pkg::swd_flags_t             far_flags,
    input  logic [swd_pkg::MIN_BITS-1:0]    min_distance,
    input  logic [swd_pkg::RATIO_BITS-1:0]  axis_ratio_q8,
    output logic [swd_pkg::DIR_BITS-1:0]    direction
);
    import swd_pkg::*;

    localparam int C  = COORD_BITS;
    localparam int MW = (C > MIN_BITS) ? C : MIN_BITS;
    localparam int PW = C + RATIO_BITS;

    logic          too_short;
    logic [PW-1:0] major_q8;
    logic [PW-1:0] minor_scaled;
    logic          too_skewed;

    assign too_short    = MW'(far_major) < MW'(min_distance);
    assign major_q8     = PW'({far_major, 8'd0});
    assign minor_scaled = PW'(far_minor) * PW'(axis_ratio_q8);
    assign too_skewed   = major_q8 < minor_scaled;

    always_comb
    begin
        if (!tracking || too_short || too_skewed)
            direction = DIR_NONE;
        else if (far_flags.horiz)
            direction = far_flags.negative ? DIR_LEFT : DIR_RIGHT;
        else
            direction = far_flags.negative ? DIR_UP : DIR_DOWN;
    end

endmodule

FILE: design/touch_swipe_direction_detector.sv
// Touch swipe direction detector.
//
// Slave stream: one transfer per touch event. s_tuser is the op (sample or
// release); s_tdata carries the position. Master stream: one transfer per
// release, m_tdata holds the direction (none, up, down, left, right).
// Samples produce no output transfer.
//
// Timing: an input transfer lands in the input register; the tracker and
// classifier then work on it and the direction lands in the output
// register, which drives m_tvalid for a release.
// Throughput is one transfer per cycle unless a release waits on a full
// output register; the tracker state loop is combinational between its
// registers (parallel squared-distance compares, then the peak update).
// Stall: while the output register is full and not taken, a release waiting
// in the input register holds and s_tready drops; samples still flow through.
// Reset clears the tracker (no gesture) and both registers; the config
// registers return to min 24, settle 3, ratio 1.0 (Q8.8 256).
// Config writes (cfg_we/cfg_index/cfg_data) take effect at once; do them
// only while no transfer is in flight.
module touch_swipe_direction_detector #(
    parameter int COORD_BITS = 12
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    // config write port
    input  logic                                 cfg_we,
    input  logic [swd_pkg::CFG_IDX_BITS-1:0]     cfg_index,
    input  logic [swd_pkg::CFG_DATA_BITS-1:0]    cfg_data,
    // slave stream
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    input  logic [((2*COORD_BITS+7)/8)*8-1:0]    s_tdata,   // pos_x, pos_y, zero pad
    input  logic                                 s_tuser,   // op
    // master stream
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    output logic [swd_pkg::OUT_TDATA_BITS-1:0]   m_tdata    // direction, zero pad
);
    import swd_pkg::*;

    localparam int C = COORD_BITS;

    // config registers; settle distance kept squared
    logic [MIN_BITS-1:0]       min_dist_reg;
    logic [SETTLE_SQ_BITS-1:0] settle_sq_reg;
    logic [RATIO_BITS-1:0]     ratio_reg;
    logic [SETTLE_BITS-1:0]    cfg_settle;

    // input register
    logic         in_valid_reg;
    logic         in_op_reg;
    logic [C-1:0] in_x_reg, in_y_reg;

    // output register
    logic                out_valid_reg;
    logic [DIR_BITS-1:0] out_dir_reg;

    logic                out_free;
    logic                advance;
    logic                tracking;
    logic [C-1:0]        far_major, far_minor;
    swd_flags_t          far_flags;
    logic [DIR_BITS-1:0] direction;

    assign cfg_settle = cfg_data[SETTLE_BITS-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_dist_reg  <= MIN_DISTANCE_RST;
            settle_sq_reg <= SETTLE_SQ_RST;
            ratio_reg     <= AXIS_RATIO_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_MIN_DISTANCE:    min_dist_reg  <= cfg_data[MIN_BITS-1:0];
                CFG_SETTLE_DISTANCE: settle_sq_reg <= SETTLE_SQ_BITS'(cfg_settle)
                                                      * SETTLE_SQ_BITS'(cfg_settle);
                CFG_AXIS_RATIO:      ratio_reg     <= cfg_data[RATIO_BITS-1:0];
                default:             ;  // unmapped index, ignored
            endcase
        end
    end

    // a release needs a free output slot, a sample never waits
    assign out_free = !out_valid_reg || m_tready;
    assign advance  = in_valid_reg && (in_op_reg == OP_SAMPLE || out_free);
    assign s_tready = !in_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            in_op_reg <= s_tuser;
            in_x_reg  <= s_tdata[C-1:0];
            in_y_reg  <= s_tdata[2*C-1:C];
        end
    end

    swd_tracker #(
        .COORD_BITS(COORD_BITS)
    ) u_tracker (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (advance),
        .op        (in_op_reg),
        .pos_x     (in_x_reg),
        .pos_y     (in_y_reg),
        .settle_sq (settle_sq_reg),
        .tracking  (tracking),
        .far_major (far_major),
        .far_minor (far_minor),
        .far_flags (far_flags)
    );

    swd_classify #(
        .COORD_BITS(COORD_BITS)
    ) u_classify (
        .tracking      (tracking),
        .far_major     (far_major),
        .far_minor     (far_minor),
        .far_flags     (far_flags),
        .min_distance  (min_dist_reg),
        .axis_ratio_q8 (ratio_reg),
        .direction     (direction)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance && in_op_reg == OP_RELEASE)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && in_op_reg == OP_RELEASE)
        begin
            out_dir_reg <= direction;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {(OUT_TDATA_BITS-DIR_BITS)'(0), out_dir_reg};

endmodule

FILE: design/swd_checker.sv
module swd_checker (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 s_tready,
    input  logic                                 m_tvalid,
    input  logic                                 m_tready,
    input  logic [swd_pkg::OUT_TDATA_BITS-1:0]   m_tdata
);
    import swd_pkg::*;

    // stalled output transfer holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("output changed while stalled");

    // only legal direction codes, padding zero
    a_out_code: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tdata[DIR_BITS-1:0] <= DIR_RIGHT
                     && m_tdata[OUT_TDATA_BITS-1:DIR_BITS] == '0)
        else $error("illegal direction code");

    // input back-pressure only comes from a blocked output
    a_bp_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> m_tvalid && !m_tready)
        else $error("input stalled with output free");

    // nothing pending right after reset
    a_rst_empty: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rst_n) |-> !m_tvalid && s_tready)
        else $error("pipeline not empty after reset");

endmodule

bind touch_swipe_direction_detector swd_checker u_swd_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
